// File: rtl/core/chained_hash_map_defines.svh
// Assertion macros for the chained hash map RTL.
// Uses clk and arst_n from the including module; no other dependencies.
`ifndef CHAINED_HASH_MAP_DEFINES_SVH
`define CHAINED_HASH_MAP_DEFINES_SVH
`ifndef SYNTHESIS
`define CHM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define CHM_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define CHM_ASSERT(label, prop, msg)
`define CHM_NEVER(label, expr, msg)
`endif
`endif

// File: rtl/core/chm_pkg.sv
// Shared types and constants of the chained hash map.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package chm_pkg;
	localparam int KEY_W  = 31;
	localparam int DATA_W = 32;
	localparam int MODE_W = 2;

	// key reduction: bits folded per cycle and folding steps per key
	localparam int HASH_BITS  = 8;
	localparam int HASH_W     = KEY_W + 1;
	localparam int HASH_STEPS = HASH_W / HASH_BITS;
	localparam int HCNT_W     = $clog2(HASH_STEPS);

	localparam logic [MODE_W-1:0] MODE_SET = 2'd0;
	localparam logic [MODE_W-1:0] MODE_GET = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DEL = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_HASH, S_HRD, S_HCHK, S_NRD, S_NCHK,
		S_MISS, S_PRD, S_PCHK, S_RESP
	} chm_state_t;
endpackage
`default_nettype wire

// File: rtl/core/chm_if.sv
// Request and response channel interfaces of the chained hash map.
// Depends on chm_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface chm_req_if import chm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [KEY_W-1:0]  key;
	logic signed [DATA_W-1:0] value;
	modport source (output valid, mode, key, value, input ready);
	modport sink (input valid, mode, key, value, output ready);
endinterface

interface chm_rsp_if import chm_pkg::*; ();
	logic valid;
	logic ready;
	logic found;
	logic signed [DATA_W-1:0] read_value;
	logic pool_full;
	modport source (output valid, found, read_value, pool_full, input ready);
	modport sink (input valid, found, read_value, pool_full, output ready);
endinterface
`default_nettype wire

// File: rtl/core/chm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module chm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: rtl/core/chm_bucket.sv
// Key to bucket reduction: key modulo BUCKETS, eight key bits per cycle.
// Depends on chm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module chm_bucket import chm_pkg::*; #(
	parameter int BUCKETS = 64,
	localparam int BIW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [KEY_W-1:0] key,
	output logic                  done,
	output logic      [BIW-1:0]   bucket
);
	localparam int RW = BIW + 1;

	logic [HASH_W-1:0] sh_q;
	logic [BIW-1:0]    r_q;
	logic [BIW-1:0]    r_next;
	logic [HCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	// restoring remainder, MSB first
	always_comb begin
		logic [RW-1:0] t;
		r_next = r_q;
		for (int i = 0; i < HASH_BITS; i++) begin
			t = {r_next, sh_q[HASH_W-1-i]};
			if (t >= RW'(BUCKETS)) begin
				t = t - RW'(BUCKETS);
			end
			r_next = t[BIW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == HCNT_W'(HASH_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q <= {1'b0, key};
			r_q  <= '0;
		end else if (busy_q) begin
			sh_q <= sh_q << HASH_BITS;
			r_q  <= r_next;
		end
	end

	assign done   = done_q;
	assign bucket = r_q;
endmodule
`default_nettype wire

// File: rtl/core/chained_hash_map.sv
// Top level of the chained hash map: sequencer, bucket heads, node pool, free stack.
// Depends on chm_pkg, chm_if, chm_ram, chm_bucket and chained_hash_map_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "chained_hash_map_defines.svh"
// Key-value store with separate chaining, one request at a time. A request
// (mode, key, value) enters when req.ready is high; the bucket is key modulo
// BUCKETS. Each item runs through key reduction (four folding steps and the
// done state), the bucket head read (a nop goes straight to the response), a
// read and a check per chain node visited (node memory read port, one node per
// visit), a miss state when the key is absent and a free stack read when a set
// pulls a node from the free stack, then the response register load and the
// return to idle to take the next item. The response register lets the next
// item enter while a result waits. After reset the bucket head memory is swept
// to empty, one entry per cycle, so req.ready stays low until the sweep ends.
module chained_hash_map import chm_pkg::*; #(
	parameter int BUCKETS    = 64,
	parameter int POOL_NODES = 256
) (
	input  wire logic clk,
	input  wire logic arst_n,
	chm_req_if.sink   req,
	chm_rsp_if.source rsp
);
	localparam int BIW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int NW  = $clog2(POOL_NODES);
	localparam int PW  = NW + 1;              // node pointer, POOL_NODES is null
	localparam logic [PW-1:0] NIL = PW'(POOL_NODES);

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] data;
		logic [PW-1:0]     link;
	} node_t;

	chm_state_t state_q, state_d;

	// request and walk registers
	logic [MODE_W-1:0] mode_q;
	logic [KEY_W-1:0]  key_q;
	logic [DATA_W-1:0] val_q;
	logic [PW-1:0]     cur_q;
	logic [PW-1:0]     prev_q;
	logic [PW-1:0]     head_q;
	node_t             prev_ent_q;
	logic              res_found_q;
	logic [DATA_W-1:0] res_rd_q;
	logic              res_full_q;

	// pool bookkeeping; lw_q is the lowest stack depth ever reached, so
	// stack slots below it were never written and are taken as identity
	logic [PW-1:0]  fc_q;
	logic [PW-1:0]  lw_q;
	logic [PW-1:0]  fc_m1;
	logic [BIW-1:0] clr_q;

	// response register
	logic              out_valid_q;
	logic              found_q;
	logic [DATA_W-1:0] rd_q;
	logic              full_q;

	// memory ports
	logic           head_we;
	logic [BIW-1:0] head_waddr;
	logic [PW-1:0]  head_wdata;
	logic [PW-1:0]  head_rdata;
	logic           node_we;
	logic [NW-1:0]  node_waddr;
	node_t          node_wdata;
	node_t          node_rdata;
	logic           stk_we;
	logic [NW-1:0]  stk_rdata;
	logic [NW-1:0]  new_node;

	logic           bkt_start;
	logic           bkt_done;
	logic [BIW-1:0] bkt_idx;
	logic           hit;
	logic           resp_go;
	logic           accept;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign bkt_start = accept;
	assign fc_m1     = fc_q - 1'b1;
	assign hit       = (node_rdata.key == key_q);
	assign resp_go   = (state_q == S_RESP) && (!out_valid_q || rsp.ready);
	// fresh slot if this depth was never popped before
	assign new_node  = (fc_q <= lw_q) ? fc_m1[NW-1:0] : stk_rdata;

	chm_bucket #(.BUCKETS(BUCKETS)) u_bucket (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bkt_start),
		.key    (req.key),
		.done   (bkt_done),
		.bucket (bkt_idx)
	);

	chm_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_head_ram (
		.clk   (clk),
		.we    (head_we),
		.waddr (head_waddr),
		.wdata (head_wdata),
		.raddr (bkt_idx),
		.rdata (head_rdata)
	);

	chm_ram #(.WIDTH($bits(node_t)), .DEPTH(POOL_NODES)) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (node_wdata),
		.raddr (cur_q[NW-1:0]),
		.rdata (node_rdata)
	);

	chm_ram #(.WIDTH(NW), .DEPTH(POOL_NODES)) u_free_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (fc_q[NW-1:0]),
		.wdata (cur_q[NW-1:0]),
		.raddr (fc_m1[NW-1:0]),
		.rdata (stk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state and memory writes
	always_comb begin
		state_d    = state_q;
		head_we    = 1'b0;
		head_waddr = bkt_idx;
		head_wdata = NIL;
		node_we    = 1'b0;
		node_waddr = cur_q[NW-1:0];
		node_wdata = '{key: key_q, data: val_q, link: node_rdata.link};
		stk_we     = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				head_we    = 1'b1;
				head_waddr = clr_q;
				if (clr_q == BIW'(BUCKETS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req.valid) begin
					state_d = S_HASH;
				end
			end
			S_HASH: begin
				if (bkt_done) begin
					state_d = (mode_q == MODE_NOP) ? S_RESP : S_HRD;
				end
			end
			S_HRD: state_d = S_HCHK;
			S_HCHK: state_d = (head_rdata == NIL) ? S_MISS : S_NRD;
			S_NRD: state_d = S_NCHK;
			S_NCHK: begin
				if (hit) begin
					state_d = S_RESP;
					case (mode_q)
						MODE_SET: node_we = 1'b1;
						MODE_DEL: begin
							// unlink: predecessor or bucket head takes our link
							if (prev_q != NIL) begin
								node_we    = 1'b1;
								node_waddr = prev_q[NW-1:0];
								node_wdata = '{key: prev_ent_q.key, data: prev_ent_q.data,
									link: node_rdata.link};
							end else begin
								head_we    = 1'b1;
								head_wdata = node_rdata.link;
							end
							stk_we = (fc_q < NIL);
						end
						default: ;
					endcase
				end else begin
					state_d = (node_rdata.link == NIL) ? S_MISS : S_NRD;
				end
			end
			S_MISS: begin
				state_d = (mode_q == MODE_SET && fc_q != '0) ? S_PRD : S_RESP;
			end
			S_PRD: state_d = S_PCHK;
			S_PCHK: begin
				// push new node at chain head
				node_we    = 1'b1;
				node_waddr = new_node;
				node_wdata = '{key: key_q, data: val_q, link: head_q};
				head_we    = 1'b1;
				head_wdata = {1'b0, new_node};
				state_d    = S_RESP;
			end
			S_RESP: begin
				if (resp_go) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q        <= NIL;
			lw_q        <= NIL;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (stk_we) begin
				fc_q <= fc_q + 1'b1;
			end
			if (state_q == S_PCHK) begin
				fc_q <= fc_m1;
				if (fc_m1 < lw_q) begin
					lw_q <= fc_m1;
				end
			end
			if (resp_go) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q      <= req.mode;
			key_q       <= req.key;
			val_q       <= req.value;
			res_found_q <= 1'b0;
			res_rd_q    <= '0;
			res_full_q  <= 1'b0;
		end
		if (state_q == S_HCHK) begin
			cur_q  <= head_rdata;
			head_q <= head_rdata;
			prev_q <= NIL;
		end
		if (state_q == S_NCHK) begin
			if (hit) begin
				res_found_q <= 1'b1;
				if (mode_q == MODE_GET) begin
					res_rd_q <= node_rdata.data;
				end
			end else begin
				prev_q     <= cur_q;
				prev_ent_q <= node_rdata;
				cur_q      <= node_rdata.link;
			end
		end
		if (state_q == S_MISS) begin
			if (mode_q == MODE_GET) begin
				res_rd_q <= '1;
			end
			if (mode_q == MODE_SET && fc_q == '0) begin
				res_full_q <= 1'b1;
			end
		end
		if (resp_go) begin
			found_q <= res_found_q;
			rd_q    <= res_rd_q;
			full_q  <= res_full_q;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.found      = found_q;
	assign rsp.read_value = rd_q;
	assign rsp.pool_full  = full_q;

	`CHM_NEVER(a_fc_range, fc_q > NIL, "free count above pool size")
	`CHM_NEVER(a_lw_order, lw_q > fc_q, "low-water mark above free count")
	`CHM_ASSERT(a_pop_nonempty, state_q == S_PCHK |-> fc_q != '0, "pop from empty free stack")
	`CHM_ASSERT(a_walk_ptr, state_q == S_NRD |-> cur_q < NIL, "chain walk on null pointer")
endmodule
`default_nettype wire
